// File: design/mbe_pkg.sv
// Shared types, register indexes and constants of the escape-time evaluator
`default_nettype none
package mbe_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int DIM_BITS       = 13;
    localparam int ITER_BITS      = 16;
    localparam int MUL_DIGIT_BITS = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 2'd2;

    localparam logic [DIM_BITS-1:0]  FRAME_WIDTH_RST    = 13'd500;
    localparam logic [DIM_BITS-1:0]  FRAME_HEIGHT_RST   = 13'd300;
    localparam logic [ITER_BITS-1:0] MAX_ITERATIONS_RST = 16'd50;

    typedef enum logic [1:0] {
        MUL_XX,
        MUL_YY,
        MUL_XY
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_RE,
        ST_DIV_IM,
        ST_CHECK,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_XY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    div_sel_im;
        logic    take_re;
        logic    take_im;
        logic    mul_start;
        mul_op_t mul_op;
        logic    take_xx;
        logic    take_yy;
        logic    update;
        logic    finish;
    } mbe_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic limit_hit;
        logic box_escape;
        logic sum_escape;
    } mbe_status_t;

endpackage
`default_nettype wire

// File: design/mandelbrot_escape_time.sv
// Top level of the escape-time evaluator: controller plus datapath
//
// channel  dir  handshake             payload
// in       in   in_valid / in_stall   pixel_col, pixel_row
// out      out  out_valid / out_stall out_col, out_row, iteration_count, inside_set
// cfg      in   cfg_we                cfg_index, cfg_data
//
// One item at a time. Two scaling divisions come first (one quotient bit a cycle;
// a saturated axis skips the bit loop), then each iteration makes one check and the
// multiplies x*x, y*y and 2*x*y (2*x*y skipped on a sum escape), each over ND =
// ceil((FRAC_BITS+3)/16) digits, one multiplier digit a cycle.
// Reset clears control state and loads the register defaults; no clearing pass.
// A new item is taken while the previous result waits on out_stall.
`default_nettype none
module mandelbrot_escape_time #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 26
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [COORD_BITS-1:0]              pixel_col,
    input  wire logic [COORD_BITS-1:0]              pixel_row,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [COORD_BITS-1:0]                   out_col,
    output logic [COORD_BITS-1:0]                   out_row,
    output logic [mbe_pkg::ITER_BITS-1:0]           iteration_count,
    output logic                                    inside_set,
    input  wire logic                               cfg_we,
    input  wire logic [mbe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mbe_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    mbe_pkg::mbe_cmd_t    cmd;
    mbe_pkg::mbe_status_t status;

    mbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    mbe_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pixel_col       (pixel_col),
        .pixel_row       (pixel_row),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_col         (out_col),
        .out_row         (out_row),
        .iteration_count (iteration_count),
        .inside_set      (inside_set)
    );

endmodule
`default_nettype wire

// File: design/mbe_div.sv
// Restoring divider: (2*num)/den as a signed fixed-point word, one quotient bit a cycle
`default_nettype none
module mbe_div #(
    parameter int NUM_BITS  = 14,
    parameter int FRAC_BITS = 26
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [NUM_BITS-1:0]          num,
    input  wire logic [mbe_pkg::DIM_BITS-1:0]        den,
    output logic                                     done,
    output logic signed [FRAC_BITS+5:0]              quot
);

    localparam int WORD_BITS = FRAC_BITS + 6;
    localparam int QB        = FRAC_BITS + 5;
    localparam int R_BITS    = mbe_pkg::DIM_BITS + 5;
    localparam int CW        = ((NUM_BITS > R_BITS) ? NUM_BITS : R_BITS) + 1;
    localparam int CNT_BITS  = $clog2(QB);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(QB - 1);
    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                neg_reg;
    logic                sat_reg;
    logic [QB-1:0]       q_reg;
    logic [R_BITS-1:0]   r_reg;
    logic [R_BITS-1:0]   den32_reg;

    logic [NUM_BITS-1:0] num_mag;
    logic [CW-1:0]       n_ext;
    logic [R_BITS-1:0]   den32;
    logic                start_sat;
    logic [R_BITS:0]     r2;
    logic [R_BITS:0]     r_diff;
    logic                ge;
    logic [WORD_BITS-1:0] q_adj;

    assign num_mag   = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
    assign n_ext     = CW'({num_mag[NUM_BITS-2:0], 1'b0});
    assign den32     = {den, 5'b00000};
    assign start_sat = n_ext >= CW'(den32);

    assign r2     = {r_reg, 1'b0};
    assign r_diff = r2 - {1'b0, den32_reg};
    assign ge     = r2 >= {1'b0, den32_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = !start_sat;
            done_next = start_sat;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg   <= num[NUM_BITS-1];
            sat_reg   <= start_sat;
            den32_reg <= den32;
            r_reg     <= n_ext[R_BITS-1:0];
            q_reg     <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? r_diff[R_BITS-1:0] : r2[R_BITS-1:0];
            q_reg <= {q_reg[QB-2:0], ge};
        end
    end

    // negative quotients round toward minus infinity: bump magnitude on a remainder
    assign q_adj = {1'b0, q_reg} + WORD_BITS'(neg_reg && (r_reg != '0));
    assign done  = done_reg;

    always_comb
    begin
        if (sat_reg)
            quot = neg_reg ? WORD_MIN : WORD_MAX;
        else if (neg_reg)
            quot = ~q_adj + 1'b1;
        else
            quot = q_adj;
    end

endmodule
`default_nettype wire

// File: design/mbe_mul.sv
// Sign-magnitude multiplier, one 16-bit digit of b a cycle, floored fixed-point result
`default_nettype none
module mbe_mul #(
    parameter int MAG_BITS  = 29,
    parameter int FRAC_BITS = 26
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [MAG_BITS-1:0]       a_mag,
    input  wire logic [MAG_BITS-1:0]       b_mag,
    input  wire logic                      neg,
    output logic                           done,
    output logic signed [FRAC_BITS+5:0]    prod
);

    localparam int WORD_BITS = FRAC_BITS + 6;
    localparam int DIG       = mbe_pkg::MUL_DIGIT_BITS;
    localparam int ND        = (MAG_BITS + DIG - 1) / DIG;
    localparam int BW        = ND * DIG;
    localparam int SW        = MAG_BITS + DIG;
    localparam int PW        = MAG_BITS + BW;
    localparam int CNT_BITS  = $clog2(ND + 1);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(ND - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [MAG_BITS-1:0] a_reg;
    logic [BW-1:0]       b_reg;
    logic [MAG_BITS-1:0] acc_reg;
    logic [BW-1:0]       lo_reg;
    logic                neg_reg;

    logic [SW-1:0]        part;
    logic [SW-1:0]        sum;
    logic [BW+DIG-1:0]    lo_cat;
    logic [BW+DIG-1:0]    b_cat;
    logic [PW-1:0]        full;
    logic [WORD_BITS-1:0] m;
    logic [WORD_BITS-1:0] m_adj;
    logic                 sticky;

    assign part   = a_reg * b_reg[DIG-1:0];
    assign sum    = SW'(acc_reg) + part;
    assign lo_cat = {sum[DIG-1:0], lo_reg};
    assign b_cat  = {{DIG{1'b0}}, b_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // low digits drop into lo_reg, so {acc, lo} ends as the full product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_mag;
            b_reg   <= BW'(b_mag);
            neg_reg <= neg;
            acc_reg <= '0;
            lo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum[SW-1:DIG];
            lo_reg  <= lo_cat[BW+DIG-1:DIG];
            b_reg   <= b_cat[BW+DIG-1:DIG];
        end
    end

    assign full   = {acc_reg, lo_reg};
    assign m      = full[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
    assign sticky = |full[FRAC_BITS-1:0];
    assign m_adj  = m + WORD_BITS'(sticky);
    assign done   = done_reg;

    always_comb
    begin
        if (neg_reg)
            prod = ~m_adj + 1'b1;
        else
            prod = m;
    end

endmodule
`default_nettype wire

// File: design/mbe_datapath.sv
// Datapath: configuration registers, pixel and orbit registers, divider and multiplier
`default_nettype none
module mbe_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 26
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire mbe_pkg::mbe_cmd_t                    cmd,
    output mbe_pkg::mbe_status_t                      status,
    input  wire logic [COORD_BITS-1:0]                pixel_col,
    input  wire logic [COORD_BITS-1:0]                pixel_row,
    input  wire logic                                 cfg_we,
    input  wire logic [mbe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [mbe_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic [COORD_BITS-1:0]                     out_col,
    output logic [COORD_BITS-1:0]                     out_row,
    output logic [mbe_pkg::ITER_BITS-1:0]             iteration_count,
    output logic                                      inside_set
);

    localparam int WORD_BITS = FRAC_BITS + 6;
    localparam int MAG_BITS  = FRAC_BITS + 3;
    localparam int NUM_BITS  = (COORD_BITS + 2 > mbe_pkg::DIM_BITS + 1) ?
                               COORD_BITS + 2 : mbe_pkg::DIM_BITS + 1;
    localparam logic signed [WORD_BITS-1:0] TWO      = WORD_BITS'(1) << (FRAC_BITS + 1);
    localparam logic signed [WORD_BITS-1:0] NEG_TWO  = -TWO;
    localparam logic signed [WORD_BITS:0]   FOUR     = (WORD_BITS+1)'(1) << (FRAC_BITS + 2);
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [mbe_pkg::DIM_BITS-1:0]  width_reg;
    logic [mbe_pkg::DIM_BITS-1:0]  height_reg;
    logic [mbe_pkg::ITER_BITS-1:0] iter_max_reg;

    logic [COORD_BITS-1:0]         col_reg;
    logic [COORD_BITS-1:0]         row_reg;
    logic signed [WORD_BITS-1:0]   c_re_reg;
    logic signed [WORD_BITS-1:0]   c_im_reg;
    logic signed [WORD_BITS-1:0]   x_reg;
    logic signed [WORD_BITS-1:0]   y_reg;
    logic signed [WORD_BITS-1:0]   xx_reg;
    logic signed [WORD_BITS-1:0]   yy_reg;
    logic [mbe_pkg::ITER_BITS-1:0] iter_reg;

    logic [COORD_BITS-1:0]         out_col_reg;
    logic [COORD_BITS-1:0]         out_row_reg;
    logic [mbe_pkg::ITER_BITS-1:0] out_iter_reg;
    logic                          out_inside_reg;

    logic [mbe_pkg::DIM_BITS-1:0]  w_eff;
    logic signed [NUM_BITS-1:0]    num_re;
    logic signed [NUM_BITS-1:0]    num_im;
    logic signed [NUM_BITS-1:0]    div_num;
    logic                          div_done;
    logic signed [WORD_BITS-1:0]   div_quot;

    logic [WORD_BITS-1:0]          x_mag;
    logic [WORD_BITS-1:0]          y_mag;
    logic [WORD_BITS:0]            x_mag2;
    logic [MAG_BITS-1:0]           mul_a;
    logic [MAG_BITS-1:0]           mul_b;
    logic                          mul_neg;
    logic                          mul_done;
    logic signed [WORD_BITS-1:0]   mul_prod;

    logic signed [WORD_BITS:0]     sum_sq;
    logic signed [WORD_BITS+1:0]   nx_full;
    logic signed [WORD_BITS+1:0]   ny_full;
    logic signed [WORD_BITS-1:0]   nx;
    logic signed [WORD_BITS-1:0]   ny;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [WORD_BITS+1:0] v
    );
        logic signed [WORD_BITS-1:0] r;
        if (v[WORD_BITS+1:WORD_BITS-1] == 3'b000 || v[WORD_BITS+1:WORD_BITS-1] == 3'b111)
            r = v[WORD_BITS-1:0];
        else if (v[WORD_BITS+1])
            r = WORD_MIN;
        else
            r = WORD_MAX;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= mbe_pkg::FRAME_WIDTH_RST;
            height_reg   <= mbe_pkg::FRAME_HEIGHT_RST;
            iter_max_reg <= mbe_pkg::MAX_ITERATIONS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbe_pkg::REG_FRAME_WIDTH:    width_reg    <= cfg_data[mbe_pkg::DIM_BITS-1:0];
                mbe_pkg::REG_FRAME_HEIGHT:   height_reg   <= cfg_data[mbe_pkg::DIM_BITS-1:0];
                mbe_pkg::REG_MAX_ITERATIONS: iter_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero width behaves as one
    assign w_eff   = (width_reg == '0) ? mbe_pkg::DIM_BITS'(1) : width_reg;
    assign num_re  = NUM_BITS'({col_reg, 1'b0}) - NUM_BITS'(w_eff);
    assign num_im  = NUM_BITS'({row_reg, 1'b0}) - NUM_BITS'(height_reg);
    assign div_num = cmd.div_sel_im ? num_im : num_re;

    mbe_div #(
        .NUM_BITS  (NUM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (w_eff),
        .done  (div_done),
        .quot  (div_quot)
    );

    // operands are only used once |x|,|y| <= 2 has been checked
    assign x_mag  = x_reg[WORD_BITS-1] ? WORD_BITS'(-x_reg) : WORD_BITS'(x_reg);
    assign y_mag  = y_reg[WORD_BITS-1] ? WORD_BITS'(-y_reg) : WORD_BITS'(y_reg);
    assign x_mag2 = {x_mag, 1'b0};

    always_comb
    begin
        case (cmd.mul_op)
            mbe_pkg::MUL_XX:
            begin
                mul_a   = x_mag[MAG_BITS-1:0];
                mul_b   = x_mag[MAG_BITS-1:0];
                mul_neg = 1'b0;
            end
            mbe_pkg::MUL_YY:
            begin
                mul_a   = y_mag[MAG_BITS-1:0];
                mul_b   = y_mag[MAG_BITS-1:0];
                mul_neg = 1'b0;
            end
            mbe_pkg::MUL_XY:
            begin
                mul_a   = x_mag2[MAG_BITS-1:0];
                mul_b   = y_mag[MAG_BITS-1:0];
                mul_neg = x_reg[WORD_BITS-1] ^ y_reg[WORD_BITS-1];
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    mbe_mul #(
        .MAG_BITS  (MAG_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a_mag (mul_a),
        .b_mag (mul_b),
        .neg   (mul_neg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // y*y arrives straight from the multiplier when the sum is tested
    assign sum_sq  = {xx_reg[WORD_BITS-1], xx_reg} + {mul_prod[WORD_BITS-1], mul_prod};
    assign nx_full = {{2{xx_reg[WORD_BITS-1]}}, xx_reg} - {{2{yy_reg[WORD_BITS-1]}}, yy_reg}
                   + {{2{c_re_reg[WORD_BITS-1]}}, c_re_reg};
    assign ny_full = {{2{mul_prod[WORD_BITS-1]}}, mul_prod}
                   + {{2{c_im_reg[WORD_BITS-1]}}, c_im_reg};
    assign nx      = sat_word(nx_full);
    assign ny      = sat_word(ny_full);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg  <= pixel_col;
            row_reg  <= pixel_row;
            x_reg    <= '0;
            y_reg    <= '0;
            iter_reg <= '0;
        end
        else if (cmd.update)
        begin
            x_reg    <= nx;
            y_reg    <= ny;
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.take_re)
            c_re_reg <= div_quot;
        if (cmd.take_im)
            c_im_reg <= div_quot;
        if (cmd.take_xx)
            xx_reg <= mul_prod;
        if (cmd.take_yy)
            yy_reg <= mul_prod;
        if (cmd.finish)
        begin
            out_col_reg    <= col_reg;
            out_row_reg    <= row_reg;
            out_iter_reg   <= iter_reg;
            out_inside_reg <= iter_reg >= iter_max_reg;
        end
    end

    assign status.div_done   = div_done;
    assign status.mul_done   = mul_done;
    assign status.limit_hit  = iter_reg >= iter_max_reg;
    assign status.box_escape = (x_reg > TWO) || (x_reg < NEG_TWO)
                            || (y_reg > TWO) || (y_reg < NEG_TWO);
    assign status.sum_escape = sum_sq > FOUR;

    assign out_col         = out_col_reg;
    assign out_row         = out_row_reg;
    assign iteration_count = out_iter_reg;
    assign inside_set      = out_inside_reg;

endmodule
`default_nettype wire

// File: design/mbe_ctrl.sv
// Controller: sequences scaling divisions and orbit iterations, owns the handshakes
`default_nettype none
module mbe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output mbe_pkg::mbe_cmd_t          cmd,
    input  wire mbe_pkg::mbe_status_t  status
);

    mbe_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbe_pkg::ST_IDLE:
                if (in_valid)
                    state_next = mbe_pkg::ST_DIV_GO;
            mbe_pkg::ST_DIV_GO:
                state_next = mbe_pkg::ST_DIV_RE;
            mbe_pkg::ST_DIV_RE:
                if (status.div_done)
                    state_next = mbe_pkg::ST_DIV_IM;
            mbe_pkg::ST_DIV_IM:
                if (status.div_done)
                    state_next = mbe_pkg::ST_CHECK;
            mbe_pkg::ST_CHECK:
                if (status.limit_hit || status.box_escape)
                    state_next = mbe_pkg::ST_FINISH;
                else
                    state_next = mbe_pkg::ST_MUL_XX;
            mbe_pkg::ST_MUL_XX:
                if (status.mul_done)
                    state_next = mbe_pkg::ST_MUL_YY;
            mbe_pkg::ST_MUL_YY:
                if (status.mul_done)
                    state_next = status.sum_escape ? mbe_pkg::ST_FINISH : mbe_pkg::ST_MUL_XY;
            mbe_pkg::ST_MUL_XY:
                if (status.mul_done)
                    state_next = mbe_pkg::ST_CHECK;
            mbe_pkg::ST_FINISH:
                if (out_free)
                    state_next = mbe_pkg::ST_IDLE;
            default:
                state_next = mbe_pkg::ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (state_reg == mbe_pkg::ST_FINISH && out_free)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // the im division, y*y and 2*x*y start in the cycle the prior result is taken
    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = mbe_pkg::MUL_XX;
        unique case (state_reg)
            mbe_pkg::ST_IDLE:
                cmd.load = in_valid;
            mbe_pkg::ST_DIV_GO:
                cmd.div_start = 1'b1;
            mbe_pkg::ST_DIV_RE:
                if (status.div_done)
                begin
                    cmd.take_re    = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_sel_im = 1'b1;
                end
            mbe_pkg::ST_DIV_IM:
                cmd.take_im = status.div_done;
            mbe_pkg::ST_CHECK:
                cmd.mul_start = !(status.limit_hit || status.box_escape);
            mbe_pkg::ST_MUL_XX:
                if (status.mul_done)
                begin
                    cmd.take_xx   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mbe_pkg::MUL_YY;
                end
            mbe_pkg::ST_MUL_YY:
                if (status.mul_done)
                begin
                    cmd.take_yy   = 1'b1;
                    cmd.mul_start = !status.sum_escape;
                    cmd.mul_op    = mbe_pkg::MUL_XY;
                end
            mbe_pkg::ST_MUL_XY:
                cmd.update = status.mul_done;
            mbe_pkg::ST_FINISH:
                cmd.finish = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != mbe_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: design/mbe_checker.sv
// Port-level checks on the escape-time evaluator, bound to the top level
`default_nettype none
module mbe_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [mbe_pkg::ITER_BITS-1:0]      iteration_count,
    input wire logic                               inside_set,
    input wire logic                               cfg_we,
    input wire logic [mbe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input wire logic [mbe_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic [mbe_pkg::ITER_BITS-1:0] max_reg;
    logic [1:0]                    pending_reg, pending_next;
    logic                          in_take;
    logic                          out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_take && !out_take)
            pending_next = pending_reg + 1'b1;
        else if (out_take && !in_take)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg     <= mbe_pkg::MAX_ITERATIONS_RST;
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_we && cfg_index == mbe_pkg::REG_MAX_ITERATIONS)
                max_reg <= cfg_data;
        end
    end

    // a waiting result keeps its count and flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(iteration_count) && $stable(inside_set))
        else $error("result changed while stalled");

    a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_set |-> iteration_count == max_reg)
        else $error("inside point without full iteration count");

    a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_set |-> iteration_count < max_reg)
        else $error("escaped point at or above the limit");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> pending_reg <= 2'd1)
        else $error("item taken while another is still at work");

    a_result_owned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result offered with no item outstanding");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .iteration_count (iteration_count),
    .inside_set      (inside_set),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
);
`default_nettype wire
